FILE: design/ppt_pkg.sv
package ppt_pkg;

    localparam int SLOTS         = 16;
    localparam int VALUE_BITS    = 32;
    localparam int PRIORITY_BITS = 16;
    localparam int IDX_BITS      = $clog2(SLOTS);

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_PROMOTE  = 3'd1;
    localparam logic [2:0] CMD_LOOKUP   = 3'd2;
    localparam logic [2:0] CMD_GET_MAX  = 3'd3;
    localparam logic [2:0] CMD_POP_MAX  = 3'd4;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
    localparam logic [1:0] STATUS_EMPTY   = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] entry_id;
        logic [31:0] value_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] id_out;
        logic [31:0] value_out;
        logic [15:0] priority_out;
        logic        present;
    } rsp_t;

    typedef struct packed {
        logic [31:0]              id;
        logic [PRIORITY_BITS-1:0] prio;
        logic [VALUE_BITS-1:0]    value;
    } entry_t;

endpackage

FILE: design/promotable_priority_table_unit.sv
// Addressable max-priority table with SLOTS entries held in one synchronous RAM plus a row
// of valid flops. One request beat is worked at a time and yields exactly one response beat.
// Add goes from idle straight to the emit state, since the free slot comes from the valid flops
// and the RAM is written directly. Promote and lookup read the RAM one slot per cycle until
// the id matches or the last slot is read; promote writes the raised priority back in
// the cycle of the match. Get-max and pop-max always scan every slot; the single RAM read
// port, one slot per cycle, sets the length of each scan. A new request is taken once the
// previous response has moved into the output register, so a stalled response costs no
// more than one pending result.
module promotable_priority_table_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ppt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ppt_pkg::rsp_t rsp
);
    import ppt_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

    state_t              state_reg, state_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [31:0]         id_reg, id_next;
    logic [IDX_BITS-1:0] idx_reg, idx_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic [31:0]         next_id_reg, next_id_next;
    logic                best_found_reg, best_found_next;
    logic [IDX_BITS-1:0] best_idx_reg, best_idx_next;
    entry_t              best_reg, best_next;
    rsp_t                res_reg, res_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    entry_t              mem [SLOTS];
    entry_t              rd_data;
    logic [IDX_BITS-1:0] rd_addr;
    logic                mem_we;
    logic [IDX_BITS-1:0] mem_waddr;
    entry_t              mem_wdata;

    logic                free_found;
    logic [IDX_BITS-1:0] free_idx;
    logic                hit;
    logic                last;
    logic                cand_better;
    entry_t              sel;
    logic [IDX_BITS-1:0] sel_idx;
    logic                sel_found;
    logic [PRIORITY_BITS-1:0] prio_inc;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_BITS'(i);
            end
        end
    end

    assign last = (idx_reg == IDX_BITS'(SLOTS - 1));
    assign hit  = valid_reg[idx_reg] && (rd_data.id == id_reg);
    assign prio_inc = (rd_data.prio == '1) ? rd_data.prio : rd_data.prio + 1'b1;

    assign cand_better = valid_reg[idx_reg]
                         && (!best_found_reg
                             || (rd_data.prio > best_reg.prio)
                             || ((rd_data.prio == best_reg.prio) && (rd_data.id > best_reg.id)));
    assign sel       = cand_better ? rd_data : best_reg;
    assign sel_idx   = cand_better ? idx_reg : best_idx_reg;
    assign sel_found = best_found_reg || cand_better;

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        id_next         = id_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        next_id_next    = next_id_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_next       = best_reg;
        res_next        = res_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        rd_addr         = idx_reg + 1'b1;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rd_data;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                rd_addr = '0;
                if (req_valid)
                begin
                    cmd_next        = req.cmd;
                    id_next         = req.entry_id;
                    idx_next        = '0;
                    best_found_next = 1'b0;
                    res_next        = '0;
                    if (req.cmd == CMD_ADD)
                    begin
                        state_next = ST_EMIT;
                        if (free_found)
                        begin
                            mem_we               = 1'b1;
                            mem_waddr            = free_idx;
                            mem_wdata.id         = next_id_reg;
                            mem_wdata.prio       = '0;
                            mem_wdata.value      = VALUE_BITS'(req.value_in);
                            valid_next[free_idx] = 1'b1;
                            next_id_next         = next_id_reg + 32'd1;
                            res_next.id_out      = next_id_reg;
                        end
                        else
                        begin
                            res_next.status = STATUS_FULL;
                        end
                    end
                    else if (req.cmd == CMD_PROMOTE || req.cmd == CMD_LOOKUP
                             || req.cmd == CMD_GET_MAX || req.cmd == CMD_POP_MAX)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (cmd_reg == CMD_PROMOTE || cmd_reg == CMD_LOOKUP)
                begin
                    res_next.id_out = id_reg;
                    if (hit)
                    begin
                        state_next = ST_EMIT;
                        if (cmd_reg == CMD_PROMOTE)
                        begin
                            mem_we                = 1'b1;
                            mem_waddr             = idx_reg;
                            mem_wdata.prio        = prio_inc;
                            res_next.priority_out = 16'(prio_inc);
                        end
                        else
                        begin
                            res_next.present      = 1'b1;
                            res_next.value_out    = 32'(rd_data.value);
                            res_next.priority_out = 16'(rd_data.prio);
                        end
                    end
                    else if (last)
                    begin
                        state_next      = ST_EMIT;
                        res_next.status = STATUS_UNKNOWN;
                    end
                end
                else
                begin
                    best_found_next = sel_found;
                    best_idx_next   = sel_idx;
                    best_next       = sel;
                    if (last)
                    begin
                        state_next = ST_EMIT;
                        if (sel_found)
                        begin
                            res_next.id_out       = sel.id;
                            res_next.value_out    = 32'(sel.value);
                            res_next.priority_out = 16'(sel.prio);
                            if (cmd_reg == CMD_POP_MAX)
                            begin
                                valid_next[sel_idx] = 1'b0;
                            end
                        end
                        else
                        begin
                            res_next.status = STATUS_EMPTY;
                        end
                    end
                end
            end

            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            next_id_reg    <= '0;
            best_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            next_id_reg    <= next_id_next;
            best_found_reg <= best_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        id_reg       <= id_next;
        idx_reg      <= idx_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
